>>> hw/rtl/cpba_pkg.sv
// Shared types, constants and helper functions for the contiguous page allocator.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package cpba_pkg;

  // Widths fixed by the word formats.
  localparam int PAGE_W       = 6;
  localparam int MASK_W       = 64;
  localparam int STATUS_W     = 2;
  localparam int MAP_BITS_DEF = 64;

  // Pool size after reset, and the saturation limit of the in-use count.
  localparam logic [PAGE_W-1:0] POOL_RESET = 6'd63;
  localparam logic [PAGE_W-1:0] COUNT_MAX  = 6'd63;

  // Operation kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER_FREE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // latch an accepted request word
    logic alloc_step;  // test one window position
    logic free_step;   // retire one bit of the release mask
    logic out_load;    // copy the result into the response register
    logic cfg_we;      // pool size write
  } cpba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_free;     // request word on the input is a free
    logic skip_scan;   // allocate needs no scan (empty or oversize run)
    logic hit;         // current window is entirely free
    logic last;        // current window is the highest position
    logic rel_empty;   // no release bits left to count
  } cpba_sts_t;

  // Low n bits set, for run masks and pool masks.
  function automatic logic [MASK_W-1:0] thermo(input logic [PAGE_W-1:0] n);
    logic [MASK_W-1:0] t;
    for (int i = 0; i < MASK_W; i++) begin
      t[i] = (7'(i) < {1'b0, n});
    end
    return t;
  endfunction

endpackage

>>> hw/rtl/cpba_ifs.sv
// Handshake channels of the contiguous page allocator: request, response, pool config.
// Depends on cpba_pkg for field widths.
`timescale 1ns / 1ps

// Request channel: one word per allocate or free.
interface cpba_req_if
  import cpba_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [PAGE_W-1:0] page_count;
  logic [MASK_W-1:0] page_mask;

  modport source (output valid, kind, page_count, page_mask, input ready);
  modport sink   (input valid, kind, page_count, page_mask, output ready);
endinterface

// Response channel: one word per request.
interface cpba_rsp_if
  import cpba_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PAGE_W-1:0]   first_page;
  logic [MASK_W-1:0]   page_ids;
  logic [PAGE_W-1:0]   allocated_count;

  modport source (output valid, status, first_page, page_ids, allocated_count,
                  input ready);
  modport sink   (input valid, status, first_page, page_ids, allocated_count,
                  output ready);
endinterface

// Configuration channel: pool size write.
interface cpba_cfg_if
  import cpba_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] pool_pages;

  modport source (output valid, pool_pages, input ready);
  modport sink   (input valid, pool_pages, output ready);
endinterface

>>> hw/rtl/cpba_ctrl.sv
// Controller state machine of the page allocator: sequences accept, scan and response.
// Depends on cpba_pkg for the command and status structs.
`timescale 1ns / 1ps

module cpba_ctrl
  import cpba_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  logic      cfg_valid,
  output cpba_cmd_t cmd,
  input  cpba_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_FREE,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  // Command decode and next state.
  always_comb begin
    cmd            = '0;
    cmd.cfg_we     = cfg_valid;
    state_next     = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.is_free) begin
            state_next = S_FREE;
          end else if (sts.skip_scan) begin
            state_next = S_DONE;
          end else begin
            state_next = S_ALLOC;
          end
        end
      end
      S_ALLOC: begin
        cmd.alloc_step = 1'b1;
        if (sts.hit || sts.last) begin
          state_next = S_DONE;
        end
      end
      S_FREE: begin
        if (sts.rel_empty) begin
          state_next = S_DONE;
        end else begin
          cmd.free_step = 1'b1;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and response valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A response word appears only after the result was finished.
  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("response valid rose outside the done state");

  // The response register is never overwritten while a word waits.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("response register loaded while occupied");

  // Only one request word is in work at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request accepted during work");

endmodule

>>> hw/rtl/cpba_datapath.sv
// Datapath of the page allocator: free bitmap, in-use count, window scan and response register.
// Depends on cpba_pkg for widths, codes and the command and status structs.
`timescale 1ns / 1ps

module cpba_datapath
  import cpba_pkg::*;
#(
  parameter int MAP_BITS = MAP_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cpba_cmd_t           cmd,
  output cpba_sts_t           sts,
  input  logic                kind,
  input  logic [PAGE_W-1:0]   page_count,
  input  logic [MASK_W-1:0]   page_mask,
  input  logic [PAGE_W-1:0]   pool_pages,
  output logic [STATUS_W-1:0] status,
  output logic [PAGE_W-1:0]   first_page,
  output logic [MASK_W-1:0]   page_ids,
  output logic [PAGE_W-1:0]   allocated_count
);

  // Allocator state.
  logic [MAP_BITS-1:0] pool_mask;
  logic [MAP_BITS-1:0] bitmap;
  logic [PAGE_W-1:0]   pages_in_use;

  // Per-request work registers.
  logic [MAP_BITS-1:0] win;
  logic [PAGE_W-1:0]   pos;
  logic [PAGE_W-1:0]   run_len;
  logic [MAP_BITS-1:0] rel;
  logic [STATUS_W-1:0] res_status;
  logic [PAGE_W-1:0]   res_first;
  logic [MAP_BITS-1:0] res_ids;

  // Response register.
  logic [STATUS_W-1:0] out_status;
  logic [PAGE_W-1:0]   out_first;
  logic [MAP_BITS-1:0] out_ids;
  logic [PAGE_W-1:0]   out_count;

  logic [MASK_W-1:0]   reset_full;
  logic [MASK_W-1:0]   cfg_full;
  logic [MASK_W-1:0]   run_full;
  logic [MAP_BITS-1:0] new_rel;
  logic                oversize;
  logic                fit;
  logic [PAGE_W:0]     sum;
  logic [PAGE_W-1:0]   sat_sum;

  assign reset_full = thermo(POOL_RESET);
  assign cfg_full   = thermo(pool_pages);
  assign run_full   = thermo(page_count);
  assign new_rel    = page_mask[MAP_BITS-1:0] & pool_mask;
  assign oversize   = ({1'b0, page_count} > (PAGE_W + 1)'(MAP_BITS));

  // Window test and saturating count update.
  assign fit     = ((bitmap & win) == win);
  assign sum     = {1'b0, pages_in_use} + {1'b0, run_len};
  assign sat_sum = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[PAGE_W-1:0];

  // Status toward the controller.
  always_comb begin
    sts.is_free   = (kind == KIND_FREE);
    sts.skip_scan = (page_count == '0) || oversize;
    sts.hit       = fit;
    sts.last      = win[MAP_BITS-1];
    sts.rel_empty = (rel == '0);
  end

  // Bitmap, pool mask and in-use count.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_mask    <= reset_full[MAP_BITS-1:0];
      bitmap       <= reset_full[MAP_BITS-1:0];
      pages_in_use <= '0;
    end else if (cmd.cfg_we) begin
      pool_mask    <= cfg_full[MAP_BITS-1:0];
      bitmap       <= cfg_full[MAP_BITS-1:0];
      pages_in_use <= '0;
    end else if (cmd.load) begin
      if (kind == KIND_FREE) begin
        bitmap <= bitmap | new_rel;
      end
    end else if (cmd.alloc_step) begin
      if (fit) begin
        bitmap       <= bitmap & ~win;
        pages_in_use <= sat_sum;
      end
    end else if (cmd.free_step) begin
      if (rel[0] && (pages_in_use != '0)) begin
        pages_in_use <= pages_in_use - 1'b1;
      end
    end
  end

  // Scan registers and result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      run_len    <= page_count;
      win        <= run_full[MAP_BITS-1:0];
      pos        <= '0;
      rel        <= new_rel;
      res_status <= ((kind == KIND_ALLOC) && oversize) ? ST_NO_SPACE : ST_OK;
      res_first  <= '0;
      res_ids    <= '0;
    end else if (cmd.alloc_step) begin
      if (fit) begin
        res_first <= pos;
        res_ids   <= win;
      end else if (win[MAP_BITS-1]) begin
        res_status <= ST_NO_SPACE;
      end else begin
        win <= win << 1;
        pos <= pos + 1'b1;
      end
    end else if (cmd.free_step) begin
      rel <= rel >> 1;
      if (rel[0] && (pages_in_use == '0)) begin
        res_status <= ST_OVER_FREE;
      end
    end
  end

  // Response register load.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= res_status;
      out_first  <= res_first;
      out_ids    <= res_ids;
      out_count  <= pages_in_use;
    end
  end

  assign status          = out_status;
  assign first_page      = out_first;
  assign page_ids        = MASK_W'(out_ids);
  assign allocated_count = out_count;

  // Granted pages are marked in use right after a hit.
  a_grant_cleared: assert property (@(posedge clk) disable iff (rst)
    (cmd.alloc_step && fit && !cmd.cfg_we) |=> ((bitmap & res_ids) == '0))
    else $error("granted pages still marked free");

  // Counting release bits never touches the bitmap.
  a_free_step_map: assert property (@(posedge clk) disable iff (rst)
    (cmd.free_step && !cmd.cfg_we) |=> $stable(bitmap))
    else $error("bitmap changed while counting released pages");

  // The scan window is never empty.
  a_win_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc_step |-> (win != '0))
    else $error("empty allocation window");

endmodule

>>> hw/rtl/contiguous_page_bitmap_allocator.sv
// Sequence: an accepted word is latched; a zero-length or oversize allocate goes straight
// to the result. Allocate: one cycle per window position tried (up to MAP_BITS-page_count+1).
// Free: one cycle per bit up to the highest released pool page. The result then waits
// until the response register is free and is loaded into it.
// Throughput: one word at a time; next request taken the cycle after the result loads.
// Reset: pool of 63 pages (capped at MAP_BITS), all free, count zero; cfg always ready.
`timescale 1ns / 1ps

module contiguous_page_bitmap_allocator
  import cpba_pkg::*;
#(
  parameter int MAP_BITS = MAP_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  cpba_cfg_if.sink          cfg,
  cpba_req_if.sink          req,
  cpba_rsp_if.source        rsp
);

  cpba_cmd_t cmd;
  cpba_sts_t sts;

  // Pool size writes are taken in any cycle.
  assign cfg.ready = 1'b1;

  // Sequencer.
  cpba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cfg_valid (cfg.valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Bitmap, count and scan.
  cpba_datapath #(
    .MAP_BITS (MAP_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .kind            (req.kind),
    .page_count      (req.page_count),
    .page_mask       (req.page_mask),
    .pool_pages      (cfg.pool_pages),
    .status          (rsp.status),
    .first_page      (rsp.first_page),
    .page_ids        (rsp.page_ids),
    .allocated_count (rsp.allocated_count)
  );

endmodule

>>> sim/contiguous_page_bitmap_allocator_tb.sv
// Self-checking testbench for the contiguous page bitmap allocator.
// Drives the request and pool channels, predicts every response word, and checks it.
// Depends on cpba_pkg, the channel interfaces in cpba_ifs.sv and the allocator RTL.
`timescale 1ns / 1ps

module contiguous_page_bitmap_allocator_tb;
  import cpba_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_AFTER  = 400;
  localparam int HOLD_CYCLES = 300;

  // One request word and one response word, as the channels carry them.
  typedef struct packed {
    logic              kind;
    logic [PAGE_W-1:0] page_count;
    logic [MASK_W-1:0] page_mask;
  } page_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   first_page;
    logic [MASK_W-1:0]   page_ids;
    logic [PAGE_W-1:0]   allocated_count;
  } page_grant_t;

  // A directed row; when typed is set, want is the expected response word.
  typedef struct packed {
    page_op_t    op;
    logic        typed;
    page_grant_t want;
  } script_row_t;

  localparam page_grant_t NO_GRANT = '0;

  logic clk = 1'b0;
  logic rst;

  cpba_cfg_if cfg_bus ();
  cpba_req_if req_bus ();
  cpba_rsp_if rsp_bus ();

  contiguous_page_bitmap_allocator dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the allocator state, updated at each accepted word.
  logic [MASK_W-1:0] free_map;
  logic [PAGE_W-1:0] in_use;
  logic [PAGE_W-1:0] pool_size;

  // Expected response words, oldest first.
  page_grant_t pending_grants[$];
  int          err_count = 0;
  int          grants_seen;

  // Typed expectation that travels with the word on the request channel.
  logic        row_typed;
  page_grant_t row_want;

  int burst_left = 0;
  int pool_plan[$] = '{0, 1, 2, 8, 17, 32, 48, 63};
  script_row_t script[$];

  function automatic logic [MASK_W-1:0] pool_span(input logic [PAGE_W-1:0] pages);
    return (64'd1 << pages) - 64'd1;
  endfunction

  // First-fit allocate or masked free against the given state.
  function automatic void first_fit_step(input page_op_t op,
                                         input logic [MASK_W-1:0] map,
                                         input logic [PAGE_W-1:0] used,
                                         input logic [PAGE_W-1:0] pool,
                                         output page_grant_t g,
                                         output logic [MASK_W-1:0] map_n,
                                         output logic [PAGE_W-1:0] used_n);
    logic [MASK_W-1:0] run;
    logic [MASK_W-1:0] win;
    logic [MASK_W-1:0] rel;
    logic [PAGE_W:0]   sum;
    logic              hit;
    g      = '0;
    map_n  = map;
    used_n = used;
    hit    = 1'b0;
    if (op.kind == KIND_ALLOC) begin
      // An empty run is always granted at page zero with no pages.
      if (op.page_count != '0) begin
        run = (64'd1 << op.page_count) - 64'd1;
        for (int pos = 0; pos <= MASK_W - op.page_count; pos++) begin
          win = run << pos;
          if (!hit && (map & win) == win) begin
            hit          = 1'b1;
            map_n        = map & ~win;
            g.first_page = PAGE_W'(pos);
            g.page_ids   = win;
            sum          = {1'b0, used} + {1'b0, op.page_count};
            used_n       = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[PAGE_W-1:0];
          end
        end
        if (!hit) begin
          g.status = ST_NO_SPACE;
        end
      end
    end else begin
      // Only pool pages are released; each one lowers the count, floored at zero.
      rel   = op.page_mask & pool_span(pool);
      map_n = map | rel;
      for (int b = 0; b < MASK_W; b++) begin
        if (rel[b]) begin
          if (used_n == '0) begin
            g.status = ST_OVER_FREE;
          end else begin
            used_n = used_n - 1'b1;
          end
        end
      end
    end
    g.allocated_count = used_n;
  endfunction

  // Checker and predictor: responses are compared before new words are predicted.
  always @(posedge clk) begin
    page_grant_t       got;
    page_grant_t       want;
    page_grant_t       pred;
    logic [MASK_W-1:0] map_n;
    logic [PAGE_W-1:0] used_n;
    if (rst) begin
      pool_size   <= POOL_RESET;
      free_map    <= pool_span(POOL_RESET);
      in_use      <= '0;
      grants_seen <= 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        got.status          = rsp_bus.status;
        got.first_page      = rsp_bus.first_page;
        got.page_ids        = rsp_bus.page_ids;
        got.allocated_count = rsp_bus.allocated_count;
        grants_seen <= grants_seen + 1;
        if (pending_grants.size() == 0) begin
          $display("%0t: response word with none expected, actual %h", $time, got);
          err_count++;
        end else begin
          want = pending_grants.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            err_count++;
          end
          if (got.first_page !== want.first_page) begin
            $display("%0t: first_page mismatch, expected %0d, actual %0d",
                     $time, want.first_page, got.first_page);
            err_count++;
          end
          if (got.page_ids !== want.page_ids) begin
            $display("%0t: page_ids mismatch, expected %h, actual %h",
                     $time, want.page_ids, got.page_ids);
            err_count++;
          end
          if (got.allocated_count !== want.allocated_count) begin
            $display("%0t: allocated_count mismatch, expected %0d, actual %0d",
                     $time, want.allocated_count, got.allocated_count);
            err_count++;
          end
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        pool_size <= cfg_bus.pool_pages;
        free_map  <= pool_span(cfg_bus.pool_pages);
        in_use    <= '0;
      end
      if (req_bus.valid && req_bus.ready) begin
        first_fit_step({req_bus.kind, req_bus.page_count, req_bus.page_mask},
                       free_map, in_use, pool_size, pred, map_n, used_n);
        pending_grants.push_back(row_typed ? row_want : pred);
        free_map <= map_n;
        in_use   <= used_n;
      end
    end
  end

  // Response side: random stall patterns, each held for a random stretch, plus one
  // long hold-off so that the block fills up and stops taking requests.
  int  ready_mode = 0;
  int  mode_left  = 0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_bus.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!hold_done && grants_seen >= HOLD_AFTER) begin
      rsp_bus.ready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0: rsp_bus.ready <= 1'b1;
        1: rsp_bus.ready <= 1'($urandom_range(0, 1));
        default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Run length guard.
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one word and return at the edge where it is taken. Words go out in
  // bursts; a random gap with valid low separates the bursts.
  task automatic issue(input page_op_t op, input logic typed, input page_grant_t want);
    if (burst_left == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 24);
    end
    req_bus.valid      <= 1'b1;
    req_bus.kind       <= op.kind;
    req_bus.page_count <= op.page_count;
    req_bus.page_mask  <= op.page_mask;
    row_typed          <= typed;
    row_want           <= want;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    burst_left--;
  endtask

  // Pool size write, only once the block has drained. The first edge lets the
  // checker queue the word that was accepted last.
  task automatic set_pool(input logic [PAGE_W-1:0] pages);
    req_bus.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    cfg_bus.valid      <= 1'b1;
    cfg_bus.pool_pages <= pages;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    cfg_bus.valid <= 1'b0;
  endtask

  // Random traffic: mostly allocates of short runs and frees of pages in use,
  // with some frees of arbitrary masks mixed in.
  task automatic random_ops(input int n);
    page_op_t          op;
    logic [MASK_W-1:0] busy;
    int                pick;
    for (int i = 0; i < n; i++) begin
      op.kind       = KIND_ALLOC;
      op.page_count = PAGE_W'($urandom());
      op.page_mask  = {$urandom(), $urandom()};
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          op.page_count = PAGE_W'($urandom_range(1, 6));
        end else if (pick < 85) begin
          op.page_count = PAGE_W'($urandom_range(7, 20));
        end else if (pick < 93) begin
          op.page_count = PAGE_W'($urandom_range(21, 63));
        end else if (pick < 97) begin
          op.page_count = pool_size + PAGE_W'($urandom_range(0, 1));
        end else begin
          op.page_count = '0;
        end
      end else if (pick < 90) begin
        // Release pages that are currently allocated.
        op.kind = KIND_FREE;
        busy = ~free_map & pool_span(pool_size);
        case ($urandom_range(0, 3))
          0: op.page_mask = busy;
          1, 2: op.page_mask = busy & {$urandom(), $urandom()};
          default: op.page_mask = busy | (64'd1 << $urandom_range(0, 63));
        endcase
      end else begin
        op.kind = KIND_FREE;
      end
      issue(op, 1'b0, NO_GRANT);
    end
  endtask

  // Stimulus: directed rows at the reset pool, then random phases over pool sizes.
  initial begin
    // Extremes of the run length and the mask, over-free and out-of-pool bits.
    script.push_back('{'{KIND_ALLOC, 6'd0, 64'hFFFF_0000_A5A5_5A5A}, 1'b1,
                       '{ST_OK, 6'd0, 64'd0, 6'd0}});
    script.push_back('{'{KIND_ALLOC, 6'd63, 64'd0}, 1'b1,
                       '{ST_OK, 6'd0, 64'h7FFF_FFFF_FFFF_FFFF, 6'd63}});
    script.push_back('{'{KIND_ALLOC, 6'd1, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
                       '{ST_NO_SPACE, 6'd0, 64'd0, 6'd63}});
    script.push_back('{'{KIND_FREE, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
                       '{ST_OK, 6'd0, 64'd0, 6'd0}});
    script.push_back('{'{KIND_FREE, 6'd0, 64'h8000_0000_0000_0000}, 1'b1,
                       '{ST_OK, 6'd0, 64'd0, 6'd0}});
    script.push_back('{'{KIND_FREE, 6'd21, 64'h0000_0000_0000_0001}, 1'b1,
                       '{ST_OVER_FREE, 6'd0, 64'd0, 6'd0}});
    script.push_back('{'{KIND_ALLOC, 6'd3, 64'h0000_0000_0000_0007}, 1'b1,
                       '{ST_OK, 6'd0, 64'h7, 6'd3}});
    script.push_back('{'{KIND_ALLOC, 6'd5, 64'd0}, 1'b0, NO_GRANT});
    script.push_back('{'{KIND_FREE, 6'd42, 64'h0000_0000_0000_0002}, 1'b0, NO_GRANT});
    script.push_back('{'{KIND_ALLOC, 6'd1, 64'd0}, 1'b0, NO_GRANT});
    script.push_back('{'{KIND_ALLOC, 6'd2, 64'hDEAD_BEEF_0000_0000}, 1'b0, NO_GRANT});
    script.push_back('{'{KIND_FREE, 6'd0, 64'h0000_0000_0000_0005}, 1'b0, NO_GRANT});
    script.push_back('{'{KIND_FREE, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, NO_GRANT});
    script.push_back('{'{KIND_ALLOC, 6'd62, 64'd0}, 1'b0, NO_GRANT});
    script.push_back('{'{KIND_ALLOC, 6'd2, 64'd0}, 1'b0, NO_GRANT});
    script.push_back('{'{KIND_ALLOC, 6'd1, 64'd0}, 1'b0, NO_GRANT});
    script.push_back('{'{KIND_FREE, 6'd7, 64'hC000_0000_0000_0000}, 1'b0, NO_GRANT});
    script.push_back('{'{KIND_FREE, 6'd0, 64'd0}, 1'b0, NO_GRANT});
    script.push_back('{'{KIND_FREE, 6'd1, 64'hA5A5_A5A5_A5A5_A5A5}, 1'b0, NO_GRANT});
    script.push_back('{'{KIND_ALLOC, 6'd63, 64'd0}, 1'b0, NO_GRANT});
    script.push_back('{'{KIND_FREE, 6'd0, 64'h5A5A_5A5A_5A5A_5A5A}, 1'b0, NO_GRANT});
    script.push_back('{'{KIND_ALLOC, 6'd63, 64'd0}, 1'b0, NO_GRANT});

    rst                <= 1'b1;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.pool_pages <= '0;
    req_bus.valid      <= 1'b0;
    req_bus.kind       <= KIND_ALLOC;
    req_bus.page_count <= '0;
    req_bus.page_mask  <= '0;
    row_typed          <= 1'b0;
    row_want           <= NO_GRANT;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      issue(script[i].op, script[i].typed, script[i].want);
    end
    random_ops(100);

    foreach (pool_plan[i]) begin
      set_pool(PAGE_W'(pool_plan[i]));
      random_ops(pool_plan[i] == 0 ? 40 : 115);
    end

    // Drain and let the block settle before the verdict.
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> contiguous_page_bitmap_allocator.f
hw/rtl/cpba_pkg.sv
hw/rtl/cpba_ifs.sv
hw/rtl/cpba_ctrl.sv
hw/rtl/cpba_datapath.sv
hw/rtl/contiguous_page_bitmap_allocator.sv
sim/contiguous_page_bitmap_allocator_tb.sv
